// ===== design/sorted_min_priority_queue_assert.svh =====
// assertion macros for the sorted priority queue
// clk_i and rst_ni are taken from the scope of the module that uses them
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define SMPQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smpq assertion failed");

// condition implies consequence in the next cycle
`define SMPQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smpq assertion failed");

`else

`define SMPQ_ASSERT_IMP(name, ante, cons)
`define SMPQ_ASSERT_NXT(name, ante, cons)

`endif

`endif

// ===== design/smpq_pkg.sv =====
`default_nettype none

package smpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  localparam int HOUR_BITS   = 5;
  localparam int MINUTE_BITS = 6;
  localparam int MIN_BITS    = 11;
  localparam int COUNT_BITS  = 16;
  localparam int STATUS_BITS = 2;

  localparam logic [HOUR_BITS-1:0]   MAX_HOUR         = 5'd23;
  localparam logic [MINUTE_BITS-1:0] MAX_MINUTE       = 6'd59;
  localparam logic [MIN_BITS-1:0]    MINUTES_PER_HOUR = 11'd60;

  typedef enum logic {
    REQ_SUBMIT = 1'b0,
    REQ_PICKUP = 1'b1
  } smpq_req_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } smpq_status_e;

  // broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } smpq_ctrl_t;

endpackage

`default_nettype wire

// ===== design/smpq_req_if.sv =====
`default_nettype none

interface smpq_req_if #(
  parameter int TAG_BITS = smpq_pkg::TAG_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [smpq_pkg::HOUR_BITS-1:0]    pickup_hour;
  logic [smpq_pkg::MINUTE_BITS-1:0]  pickup_minute;
  logic [TAG_BITS-1:0]               entry_tag;

  modport source (output valid, req_type, pickup_hour, pickup_minute, entry_tag,
                  input ready);
  modport sink   (input valid, req_type, pickup_hour, pickup_minute, entry_tag,
                  output ready);
endinterface

`default_nettype wire

// ===== design/smpq_rsp_if.sv =====
`default_nettype none

interface smpq_rsp_if #(
  parameter int TAG_BITS = smpq_pkg::TAG_BITS_DEF,
  parameter int OCC_BITS = $clog2(smpq_pkg::QUEUE_DEPTH_DEF + 1)
);
  logic                              valid;
  logic                              ready;
  logic [smpq_pkg::STATUS_BITS-1:0]  status;
  logic [smpq_pkg::MIN_BITS-1:0]     out_minutes;
  logic [TAG_BITS-1:0]               out_tag;
  logic [OCC_BITS-1:0]               occupancy;
  logic [smpq_pkg::COUNT_BITS-1:0]   processed_count;

  modport source (output valid, status, out_minutes, out_tag, occupancy, processed_count,
                  input ready);
  modport sink   (input valid, status, out_minutes, out_tag, occupancy, processed_count,
                  output ready);
endinterface

`default_nettype wire

// ===== design/smpq_cell.sv =====
`default_nettype none

module smpq_cell #(
  parameter int TAG_BITS = smpq_pkg::TAG_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire smpq_pkg::smpq_ctrl_t            ctrl_i,
  input  wire logic                            occupied_i,
  input  wire logic [smpq_pkg::MIN_BITS-1:0]   new_min_i,
  input  wire logic [TAG_BITS-1:0]             new_tag_i,
  input  wire logic                            left_lt_i,
  input  wire logic [smpq_pkg::MIN_BITS-1:0]   left_min_i,
  input  wire logic [TAG_BITS-1:0]             left_tag_i,
  input  wire logic [smpq_pkg::MIN_BITS-1:0]   right_min_i,
  input  wire logic [TAG_BITS-1:0]             right_tag_i,
  output logic                                 lt_o,
  output logic [smpq_pkg::MIN_BITS-1:0]        min_o,
  output logic [TAG_BITS-1:0]                  tag_o
);

  logic [smpq_pkg::MIN_BITS-1:0] min_q, min_d;
  logic [TAG_BITS-1:0]           tag_q, tag_d;

  // entries earlier than the new one stay put, the sorted order makes this a prefix
  assign lt_o = occupied_i && (min_q < new_min_i);

  always_comb begin
    min_d = min_q;
    tag_d = tag_q;
    if (ctrl_i.insert) begin
      if (!lt_o) begin
        if (left_lt_i) begin
          min_d = new_min_i;
          tag_d = new_tag_i;
        end else begin
          min_d = left_min_i;
          tag_d = left_tag_i;
        end
      end
    end else if (ctrl_i.remove) begin
      min_d = right_min_i;
      tag_d = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    tag_q <= tag_d;
  end

  assign min_o = min_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

// ===== design/sorted_min_priority_queue.sv =====
// Sorted priority queue of pick-up times held in a row of QUEUE_DEPTH cells, earliest
// entry in cell 0. A submit compares the new time against every cell at once and each
// cell either keeps its entry, takes the new one or takes its left neighbor's, so
// equal times put the newest entry first; a pick-up shifts the whole row one cell
// toward the head. One request is taken per clock cycle while the request side is
// ready, and its single response appears in the output register on the next cycle.
// The request side stays ready while the output register is empty or is being read
// in the same cycle. A submit to a full queue reports full and is dropped, a pick-up
// from an empty queue reports empty.
`default_nettype none

`include "sorted_min_priority_queue_assert.svh"

module sorted_min_priority_queue #(
  parameter int QUEUE_DEPTH = smpq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = smpq_pkg::TAG_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  smpq_req_if.sink        req_i,
  smpq_rsp_if.source      rsp_o
);

  localparam int OccW = $clog2(QUEUE_DEPTH + 1);
  localparam int MinW = smpq_pkg::MIN_BITS;
  localparam int CntW = smpq_pkg::COUNT_BITS;

  logic                      acc;
  logic                      is_pick;
  logic                      full;
  logic                      empty;
  logic                      do_ins;
  logic                      do_rem;
  logic [smpq_pkg::HOUR_BITS-1:0]   hour_sat;
  logic [smpq_pkg::MINUTE_BITS-1:0] minute_sat;
  logic [MinW-1:0]           new_min;
  smpq_pkg::smpq_ctrl_t      ctrl;

  logic [OccW-1:0]           count_q, count_d;
  logic [CntW-1:0]           processed_q, processed_d;
  logic                      out_valid_q, out_valid_d;

  smpq_pkg::smpq_status_e    status_q, status_d;
  logic [MinW-1:0]           out_min_q, out_min_d;
  logic [TAG_BITS-1:0]       out_tag_q, out_tag_d;
  logic [OccW-1:0]           occ_q;
  logic [CntW-1:0]           proc_out_q;

  logic [MinW-1:0]           cell_min [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]       cell_tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    cell_lt;
  logic [QUEUE_DEPTH-1:0]    occupied;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;
  assign is_pick     = (req_i.req_type == smpq_pkg::REQ_PICKUP);
  assign full        = (count_q == OccW'(QUEUE_DEPTH));
  assign empty       = (count_q == '0);
  assign do_ins      = acc && !is_pick && !full;
  assign do_rem      = acc && is_pick && !empty;

  assign hour_sat   = (req_i.pickup_hour > smpq_pkg::MAX_HOUR) ?
                      smpq_pkg::MAX_HOUR : req_i.pickup_hour;
  assign minute_sat = (req_i.pickup_minute > smpq_pkg::MAX_MINUTE) ?
                      smpq_pkg::MAX_MINUTE : req_i.pickup_minute;
  assign new_min    = MinW'(hour_sat) * smpq_pkg::MINUTES_PER_HOUR + MinW'(minute_sat);

  assign ctrl.insert = do_ins;
  assign ctrl.remove = do_rem;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occupied[i] = (OccW'(i) < count_q);

    smpq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied[i]),
      .new_min_i   (new_min),
      .new_tag_i   (req_i.entry_tag),
      .left_lt_i   ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1]),
      .left_min_i  (cell_min[(i == 0) ? 0 : i - 1]),
      .left_tag_i  (cell_tag[(i == 0) ? 0 : i - 1]),
      .right_min_i (cell_min[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .right_tag_i (cell_tag[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .lt_o        (cell_lt[i]),
      .min_o       (cell_min[i]),
      .tag_o       (cell_tag[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    processed_d = processed_q;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_rem) begin
      count_d = count_q - 1'b1;
      if (processed_q != '1) begin
        processed_d = processed_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (acc) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    status_d  = smpq_pkg::STATUS_OK;
    out_min_d = '0;
    out_tag_d = '0;
    if (is_pick) begin
      if (empty) begin
        status_d = smpq_pkg::STATUS_EMPTY;
      end else begin
        out_min_d = cell_min[0];
        out_tag_d = cell_tag[0];
      end
    end else if (full) begin
      status_d = smpq_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      processed_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      processed_q <= processed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q   <= status_d;
      out_min_q  <= out_min_d;
      out_tag_q  <= out_tag_d;
      occ_q      <= count_d;
      proc_out_q <= processed_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.out_minutes     = out_min_q;
  assign rsp_o.out_tag         = out_tag_q;
  assign rsp_o.occupancy       = occ_q;
  assign rsp_o.processed_count = proc_out_q;

  `SMPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= OccW'(QUEUE_DEPTH))
  `SMPQ_ASSERT_NXT(a_pick_head, do_rem, rsp_o.out_minutes == $past(cell_min[0]))
  `SMPQ_ASSERT_NXT(a_ins_count, do_ins, count_q == $past(count_q) + 1'b1)
  `SMPQ_ASSERT_IMP(a_head_sorted, count_q >= OccW'(2), cell_min[0] <= cell_min[1])

endmodule

`default_nettype wire
